[rtl/bully_leader_election_node_macros.svh]
// Assertion macros for the bully election node.
// Used by the top level only; needs no other file.
`ifndef BULLY_LEADER_ELECTION_NODE_MACROS_SVH
`define BULLY_LEADER_ELECTION_NODE_MACROS_SVH

// same-cycle implication
`define BLE_ASSERT_IMPL(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("ble assertion failed");

// next-cycle implication
`define BLE_ASSERT_NEXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("ble assertion failed");

`endif

[rtl/ble_pkg.sv]
// Types, codes, constants and the microcode table of the election node.
// No dependencies.
package ble_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_LIM  = (MAX_NODES < 16) ? MAX_NODES : 16;

  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_MSG     = 3'd1,
    MODE_START   = 3'd2,
    MODE_FAIL    = 3'd3,
    MODE_RECOVER = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    MSG_HEARTBEAT = 2'd0,
    MSG_LEADER    = 2'd1,
    MSG_ELECTION  = 2'd2,
    MSG_OKAY      = 2'd3
  } msg_t;

  typedef enum logic [2:0] {
    CFG_SELF_ID          = 3'd0,
    CFG_NODE_COUNT       = 3'd1,
    CFG_START_AS_LEADER  = 3'd2,
    CFG_HEARTBEAT_PERIOD = 3'd3,
    CFG_LEADER_TIMEOUT   = 3'd4,
    CFG_ELECTION_WAIT    = 3'd5,
    CFG_CHECK_PERIOD     = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    COND_ALWAYS = 3'd0,
    COND_HB     = 3'd1,
    COND_LD     = 3'd2,
    COND_OK     = 3'd3,
    COND_EL     = 3'd4
  } cond_t;

  localparam logic [2:0] STEP_IDLE   = 3'd0;
  localparam logic [2:0] STEP_HB     = 3'd1;
  localparam logic [2:0] STEP_LD     = 3'd2;
  localparam logic [2:0] STEP_OK     = 3'd3;
  localparam logic [2:0] STEP_EL     = 3'd4;
  localparam logic [2:0] STEP_STATUS = 3'd5;

  typedef struct packed {
    logic [3:0] self_id;
    logic [4:0] node_count;
    logic       start_as_leader;
    logic [7:0] heartbeat_period;
    logic [7:0] leader_timeout;
    logic [7:0] election_wait;
    logic [7:0] check_period;
  } cfg_t;

  typedef struct packed {
    logic hb;
    logic ld;
    logic ok;
    logic el;
  } sends_t;

  typedef struct packed {
    logic       accept;
    logic       emit;
    cond_t      cond;
    msg_t       stype;
    logic       bcast;
    logic       dest_tgt;
    logic       last;
    logic       loop;
    logic [2:0] next;
  } ctrl_t;

  typedef struct packed {
    logic       fire;
    logic       send_valid;
    logic [1:0] send_type;
    logic       broadcast;
    logic [3:0] dest_id;
    logic       last;
  } emit_t;

  function automatic logic [7:0] delay_of(input logic [7:0] d);
    return (d == 8'd0) ? 8'd1 : d;
  endfunction

  function automatic ctrl_t ucode(input logic [2:0] step);
    ctrl_t w;
    w = '0;
    w.cond  = COND_ALWAYS;
    w.stype = MSG_HEARTBEAT;
    w.next  = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.next   = STEP_HB;
      end
      STEP_HB: begin
        w.emit  = 1'b1;
        w.cond  = COND_HB;
        w.stype = MSG_HEARTBEAT;
        w.bcast = 1'b1;
        w.next  = STEP_LD;
      end
      STEP_LD: begin
        w.emit  = 1'b1;
        w.cond  = COND_LD;
        w.stype = MSG_LEADER;
        w.bcast = 1'b1;
        w.next  = STEP_OK;
      end
      STEP_OK: begin
        w.emit  = 1'b1;
        w.cond  = COND_OK;
        w.stype = MSG_OKAY;
        w.next  = STEP_EL;
      end
      STEP_EL: begin
        w.emit     = 1'b1;
        w.cond     = COND_EL;
        w.stype    = MSG_ELECTION;
        w.dest_tgt = 1'b1;
        w.loop     = 1'b1;
        w.next     = STEP_STATUS;
      end
      STEP_STATUS: begin
        w.emit = 1'b1;
        w.last = 1'b1;
        w.next = STEP_IDLE;
      end
      default: begin
        w.next = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/ble_in_if.sv]
// Request channel into the election node: valid/ready plus event fields.
// No dependencies.
interface ble_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [1:0] msg_type;
  logic [3:0] sender_id;
  logic [3:0] source_addr;

  modport source (output valid, mode, msg_type, sender_id, source_addr, input ready);
  modport sink   (input valid, mode, msg_type, sender_id, source_addr, output ready);
endinterface

[rtl/ble_out_if.sv]
// Result channel out of the election node: valid/ready plus send and status fields.
// No dependencies.
interface ble_out_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [1:0] send_type;
  logic       broadcast;
  logic [3:0] dest_id;
  logic [3:0] leader_id;
  logic       is_leader;
  logic       last;

  modport source (output valid, send_valid, send_type, broadcast, dest_id, leader_id,
                  is_leader, last, input ready);
  modport sink   (input valid, send_valid, send_type, broadcast, dest_id, leader_id,
                  is_leader, last, output ready);
endinterface

[rtl/ble_state.sv]
// Election state datapath: leader, role, timers and pending-send flags.
// Depends on ble_pkg.
module ble_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  logic [2:0]        mode,
  input  logic [1:0]        msg_type,
  input  logic [3:0]        sender_id,
  input  ble_pkg::cfg_t     cfg,
  output logic [3:0]        known_leader,
  output logic              leader_flag,
  output ble_pkg::sends_t   sends
);

  logic            leader_r, leader_nxt;
  logic [3:0]      known_r, known_nxt;
  logic            applying_r, applying_nxt;
  logic [4:0]      ok_r, ok_nxt;
  logic            working_r, working_nxt;
  logic [7:0]      sh_r, sh_nxt;
  logic [7:0]      hb_r, hb_nxt;
  logic [7:0]      ck_r, ck_nxt;
  logic [7:0]      el_r, el_nxt;
  ble_pkg::sends_t sends_r, sends_nxt;

  always_comb begin
    logic hb_due;
    logic el_due;
    logic ck_due;
    leader_nxt   = leader_r;
    known_nxt    = known_r;
    applying_nxt = applying_r;
    ok_nxt       = ok_r;
    working_nxt  = working_r;
    sh_nxt       = sh_r;
    hb_nxt       = hb_r;
    ck_nxt       = ck_r;
    el_nxt       = el_r;
    sends_nxt    = sends_r;
    hb_due       = 1'b0;
    el_due       = 1'b0;
    ck_due       = 1'b0;
    if (upd) begin
      sends_nxt = '0;
      if (mode == ble_pkg::MODE_TICK) begin
        if (sh_r != 8'hFF) sh_nxt = sh_r + 8'd1;
        if (hb_r != 8'd0) begin
          hb_nxt = hb_r - 8'd1;
          hb_due = (hb_r == 8'd1);
        end
        if (el_r != 8'd0) begin
          el_nxt = el_r - 8'd1;
          el_due = (el_r == 8'd1);
        end
        if (ck_r != 8'd0) begin
          ck_nxt = ck_r - 8'd1;
          ck_due = (ck_r == 8'd1);
        end
        if (hb_due) begin
          sends_nxt.hb = 1'b1;
          sh_nxt       = 8'd0;
          hb_nxt       = ble_pkg::delay_of(cfg.heartbeat_period);
        end
        if (el_due) begin
          if (ok_r == 5'd0) begin
            leader_nxt   = 1'b1;
            known_nxt    = cfg.self_id;
            sends_nxt.ld = 1'b1;
            hb_nxt       = 8'd1;
          end
          applying_nxt = 1'b0;
          ok_nxt       = 5'd0;
          el_nxt       = 8'd0;
        end
        if (ck_due) begin
          if (sh_nxt > cfg.leader_timeout) begin
            applying_nxt = 1'b1;
            ok_nxt       = 5'd0;
            sends_nxt.el = 1'b1;
            el_nxt       = ble_pkg::delay_of(cfg.election_wait);
          end else begin
            ck_nxt = ble_pkg::delay_of(cfg.check_period);
          end
        end
      end else if (mode == ble_pkg::MODE_MSG) begin
        if (working_r) begin
          case (msg_type)
            ble_pkg::MSG_HEARTBEAT: begin
              if (sender_id == known_r) sh_nxt = 8'd0;
            end
            ble_pkg::MSG_LEADER: begin
              known_nxt  = sender_id;
              leader_nxt = 1'b0;
              hb_nxt     = 8'd0;
              sh_nxt     = 8'd0;
              ck_nxt     = ble_pkg::delay_of(cfg.check_period);
            end
            ble_pkg::MSG_ELECTION: begin
              sends_nxt.ok = 1'b1;
              if (!applying_r) begin
                applying_nxt = 1'b1;
                ok_nxt       = 5'd0;
                sends_nxt.el = 1'b1;
                el_nxt       = ble_pkg::delay_of(cfg.election_wait);
              end
            end
            default: begin
              if (applying_r && ok_r != 5'd31) ok_nxt = ok_r + 5'd1;
            end
          endcase
        end
      end else if (mode == ble_pkg::MODE_START) begin
        if (working_r) begin
          ck_nxt = ble_pkg::delay_of(cfg.leader_timeout);
          if (cfg.start_as_leader) begin
            leader_nxt   = 1'b1;
            known_nxt    = cfg.self_id;
            sends_nxt.ld = 1'b1;
            hb_nxt       = ble_pkg::delay_of(cfg.heartbeat_period);
          end
        end
      end else if (mode == ble_pkg::MODE_FAIL) begin
        if (working_r) begin
          working_nxt = 1'b0;
          hb_nxt      = 8'd0;
          ck_nxt      = 8'd0;
          el_nxt      = 8'd0;
        end
      end else if (mode == ble_pkg::MODE_RECOVER) begin
        if (!working_r) begin
          working_nxt = 1'b1;
          ck_nxt      = 8'd1;
          if (leader_r) hb_nxt = 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leader_r   <= 1'b0;
      known_r    <= 4'd0;
      applying_r <= 1'b0;
      ok_r       <= 5'd0;
      working_r  <= 1'b1;
      sh_r       <= 8'd0;
      hb_r       <= 8'd0;
      ck_r       <= 8'd0;
      el_r       <= 8'd0;
      sends_r    <= '0;
    end else begin
      leader_r   <= leader_nxt;
      known_r    <= known_nxt;
      applying_r <= applying_nxt;
      ok_r       <= ok_nxt;
      working_r  <= working_nxt;
      sh_r       <= sh_nxt;
      hb_r       <= hb_nxt;
      ck_r       <= ck_nxt;
      el_r       <= el_nxt;
      sends_r    <= sends_nxt;
    end
  end

  assign known_leader = known_r;
  assign leader_flag  = leader_r;
  assign sends        = sends_r;

endmodule

[rtl/ble_seq.sv]
// Microcode sequencer: step counter, ROM lookup, election target counter.
// Depends on ble_pkg.
module ble_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [3:0]      in_source_addr,
  input  logic            out_free,
  input  ble_pkg::sends_t sends,
  input  ble_pkg::cfg_t   cfg,
  output logic            in_ready,
  output ble_pkg::emit_t  em
);

  logic [2:0]     step_r, step_nxt;
  logic [4:0]     tgt_r, tgt_nxt;
  logic [3:0]     src_r, src_nxt;
  logic [4:0]     lim;
  logic           cond_ok;
  logic           fire;
  logic [3:0]     dest;
  ble_pkg::ctrl_t ctrl;

  assign ctrl = ble_pkg::ucode(step_r);
  assign lim  = (cfg.node_count > 5'(ble_pkg::NODE_LIM)) ? 5'(ble_pkg::NODE_LIM)
                                                         : cfg.node_count;

  always_comb begin
    case (ctrl.cond)
      ble_pkg::COND_HB: cond_ok = sends.hb;
      ble_pkg::COND_LD: cond_ok = sends.ld;
      ble_pkg::COND_OK: cond_ok = sends.ok;
      ble_pkg::COND_EL: cond_ok = sends.el && (tgt_r < lim);
      default:          cond_ok = 1'b1;
    endcase
  end

  assign in_ready = ctrl.accept;

  always_comb begin
    step_nxt = step_r;
    tgt_nxt  = tgt_r;
    src_nxt  = src_r;
    fire     = 1'b0;
    if (ctrl.accept) begin
      if (in_valid) begin
        step_nxt = ctrl.next;
        tgt_nxt  = {1'b0, cfg.self_id} + 5'd1;
        src_nxt  = in_source_addr;
      end
    end else if (ctrl.emit && cond_ok) begin
      if (out_free) begin
        fire = 1'b1;
        if (ctrl.dest_tgt) tgt_nxt = tgt_r + 5'd1;
        if (!ctrl.loop) step_nxt = ctrl.next;
      end
    end else begin
      step_nxt = ctrl.next;
    end
  end

  assign dest = (ctrl.last || ctrl.bcast) ? 4'd0
              : (ctrl.dest_tgt ? tgt_r[3:0] : src_r);
  assign em   = {fire, !ctrl.last, (ctrl.last ? 2'd0 : ctrl.stype), ctrl.bcast, dest,
                 ctrl.last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ble_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt;
    src_r <= src_nxt;
  end

endmodule

[rtl/bully_leader_election_node.sv]
// An item's results include its election sends, at most 15 of them.
// Results leave from a single output register; status comes last, and a new
// request is accepted only after the status of the previous one has been issued.
// The sequence is set by the microcode steps: accept, heartbeat, leader, okay,
// election loop, status.
// Synchronous active-low reset clears state, sets register defaults; no clearing pass.
`include "bully_leader_election_node_macros.svh"

module bully_leader_election_node (
  input  logic             clk,
  input  logic             rst_n,
  ble_in_if.sink           in_ch,
  ble_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [7:0]       cfg_wdata
);

  ble_pkg::cfg_t   cfg_r;
  ble_pkg::sends_t sends;
  ble_pkg::emit_t  em;
  logic [3:0]      known_leader;
  logic            leader_flag;
  logic            in_ready;
  logic            out_free;
  logic            out_valid_r;
  logic            send_valid_r;
  logic [1:0]      send_type_r;
  logic            broadcast_r;
  logic [3:0]      dest_id_r;
  logic [3:0]      leader_id_r;
  logic            is_leader_r;
  logic            last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_id          <= 4'd0;
      cfg_r.node_count       <= 5'd16;
      cfg_r.start_as_leader  <= 1'b0;
      cfg_r.heartbeat_period <= 8'd5;
      cfg_r.leader_timeout   <= 8'd10;
      cfg_r.election_wait    <= 8'd10;
      cfg_r.check_period     <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        ble_pkg::CFG_SELF_ID:          cfg_r.self_id          <= cfg_wdata[3:0];
        ble_pkg::CFG_NODE_COUNT:       cfg_r.node_count       <= cfg_wdata[4:0];
        ble_pkg::CFG_START_AS_LEADER:  cfg_r.start_as_leader  <= cfg_wdata[0];
        ble_pkg::CFG_HEARTBEAT_PERIOD: cfg_r.heartbeat_period <= cfg_wdata;
        ble_pkg::CFG_LEADER_TIMEOUT:   cfg_r.leader_timeout   <= cfg_wdata;
        ble_pkg::CFG_ELECTION_WAIT:    cfg_r.election_wait    <= cfg_wdata;
        ble_pkg::CFG_CHECK_PERIOD:     cfg_r.check_period     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  ble_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (in_ch.valid && in_ready),
    .mode         (in_ch.mode),
    .msg_type     (in_ch.msg_type),
    .sender_id    (in_ch.sender_id),
    .cfg          (cfg_r),
    .known_leader (known_leader),
    .leader_flag  (leader_flag),
    .sends        (sends)
  );

  ble_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_source_addr (in_ch.source_addr),
    .out_free       (out_free),
    .sends          (sends),
    .cfg            (cfg_r),
    .in_ready       (in_ready),
    .em             (em)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (em.fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em.fire) begin
      send_valid_r <= em.send_valid;
      send_type_r  <= em.send_type;
      broadcast_r  <= em.broadcast;
      dest_id_r    <= em.dest_id;
      leader_id_r  <= known_leader;
      is_leader_r  <= leader_flag;
      last_r       <= em.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.send_valid = send_valid_r;
  assign out_ch.send_type  = send_type_r;
  assign out_ch.broadcast  = broadcast_r;
  assign out_ch.dest_id    = dest_id_r;
  assign out_ch.leader_id  = leader_id_r;
  assign out_ch.is_leader  = is_leader_r;
  assign out_ch.last       = last_r;

  `BLE_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `BLE_ASSERT_IMPL(a_status_no_send, clk, rst_n, out_ch.valid && out_ch.last, !out_ch.send_valid)
  `BLE_ASSERT_IMPL(a_send_not_last, clk, rst_n, out_ch.valid && !out_ch.last, out_ch.send_valid)
  `BLE_ASSERT_IMPL(a_elect_higher, clk, rst_n,
    out_ch.valid && out_ch.send_valid && out_ch.send_type == ble_pkg::MSG_ELECTION,
    out_ch.dest_id > cfg_r.self_id)

endmodule

[dv/testbench.sv]
// Self-checking testbench for the bully election node: directed table, then random
// event sequences, each result checked against the table or a cycle-free node model.
// Depends on ble_pkg, ble_in_if, ble_out_if and the bully_leader_election_node RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ble_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct packed {
    logic       send_valid;
    msg_t       send_type;
    logic       broadcast;
    logic [3:0] dest_id;
    logic [3:0] leader_id;
    logic       is_leader;
    logic       last;
  } node_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    cfg_t       regs;
    logic [2:0] mode;
    logic [1:0] msg;
    logic [3:0] sender;
    logic [3:0] src;
    bit         typed;
    logic [3:0] exp_leader;
    bit         exp_is_leader;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_wdata;

  ble_in_if  in_ch();
  ble_out_if out_ch();

  bully_leader_election_node DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // node model state
  cfg_t       regs;
  logic       lead_flag;
  logic [3:0] cur_leader;
  logic       campaigning;
  logic [4:0] okays;
  logic       alive;
  logic [7:0] since_hb;
  logic [8:0] hb_left;
  logic [8:0] check_left;
  logic [8:0] elect_left;

  node_out_t step_out[$];
  node_out_t pending_out[$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  results_seen = 0;
  int  settings_loaded = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  function automatic logic [8:0] hold_ticks(input logic [7:0] d);
    return (d == 8'd0) ? 9'd1 : {1'b0, d};
  endfunction

  task automatic add_send(input msg_t ty, input logic bc, input logic [3:0] dst);
    node_out_t r;
    r = '0;
    r.send_valid = 1'b1;
    r.send_type  = ty;
    r.broadcast  = bc;
    r.dest_id    = bc ? 4'd0 : dst;
    step_out.push_back(r);
  endtask

  task automatic campaign();
    int lim;
    lim = (regs.node_count > NODE_LIM) ? NODE_LIM : int'(regs.node_count);
    campaigning = 1'b1;
    okays = '0;
    for (int i = int'(regs.self_id) + 1; i < lim; i++)
      add_send(MSG_ELECTION, 1'b0, 4'(i));
    elect_left = hold_ticks(regs.election_wait);
  endtask

  task automatic predict_step(input logic [2:0] m, input logic [1:0] t,
                              input logic [3:0] s, input logic [3:0] a);
    bit        hb_due, el_due, ck_due;
    node_out_t r;
    hb_due = 1'b0;
    el_due = 1'b0;
    ck_due = 1'b0;
    step_out.delete();
    case (m)
      MODE_TICK: begin
        if (since_hb != 8'd255) since_hb++;
        if (hb_left != 0) begin
          hb_left--;
          hb_due = (hb_left == 0);
        end
        if (elect_left != 0) begin
          elect_left--;
          el_due = (elect_left == 0);
        end
        if (check_left != 0) begin
          check_left--;
          ck_due = (check_left == 0);
        end
        if (hb_due) begin
          add_send(MSG_HEARTBEAT, 1'b1, 4'd0);
          since_hb = '0;
          hb_left  = hold_ticks(regs.heartbeat_period);
        end
        if (el_due) begin
          if (okays == 0) begin
            lead_flag  = 1'b1;
            cur_leader = regs.self_id;
            add_send(MSG_LEADER, 1'b1, 4'd0);
            hb_left = 9'd1;
          end
          campaigning = 1'b0;
          okays       = '0;
          elect_left  = '0;
        end
        if (ck_due) begin
          if (since_hb > regs.leader_timeout) campaign();
          else check_left = hold_ticks(regs.check_period);
        end
      end
      MODE_MSG: begin
        if (alive) begin
          case (msg_t'(t))
            MSG_HEARTBEAT: if (s == cur_leader) since_hb = '0;
            MSG_LEADER: begin
              cur_leader = s;
              lead_flag  = 1'b0;
              hb_left    = '0;
              since_hb   = '0;
              check_left = hold_ticks(regs.check_period);
            end
            MSG_ELECTION: begin
              add_send(MSG_OKAY, 1'b0, a);
              if (!campaigning) campaign();
            end
            default: if (campaigning && okays != 5'd31) okays++;
          endcase
        end
      end
      MODE_START: begin
        if (alive) begin
          check_left = hold_ticks(regs.leader_timeout);
          if (regs.start_as_leader) begin
            lead_flag  = 1'b1;
            cur_leader = regs.self_id;
            add_send(MSG_LEADER, 1'b1, 4'd0);
            hb_left = hold_ticks(regs.heartbeat_period);
          end
        end
      end
      MODE_FAIL: begin
        if (alive) begin
          alive      = 1'b0;
          hb_left    = '0;
          check_left = '0;
          elect_left = '0;
        end
      end
      MODE_RECOVER: begin
        if (!alive) begin
          alive      = 1'b1;
          check_left = 9'd1;
          if (lead_flag) hb_left = 9'd1;
        end
      end
      default: ;
    endcase
    r = '0;
    r.last = 1'b1;
    step_out.push_back(r);
    foreach (step_out[k]) begin
      r = step_out[k];
      r.leader_id = cur_leader;
      r.is_leader = lead_flag;
      step_out[k] = r;
    end
  endtask

  task automatic offer(input logic [2:0] m, input logic [1:0] t, input logic [3:0] s,
                       input logic [3:0] a, input bit typed = 1'b0,
                       input logic [3:0] want_leader = '0, input bit want_lead = 1'b0);
    node_out_t status;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.msg_type    <= t;
    in_ch.sender_id   <= s;
    in_ch.source_addr <= a;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_step(m, t, s, a);
    if (typed) begin
      status           = '0;
      status.leader_id = want_leader;
      status.is_leader = want_lead;
      status.last      = 1'b1;
      pending_out.push_back(status);
    end else begin
      foreach (step_out[k]) pending_out.push_back(step_out[k]);
    end
    requests_sent++;
  endtask

  task automatic load_regs(input cfg_t c);
    in_ch.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = CFG_SELF_ID; i <= CFG_CHECK_PERIOD; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      case (cfg_idx_t'(i))
        CFG_SELF_ID:          cfg_wdata <= {4'b0, c.self_id};
        CFG_NODE_COUNT:       cfg_wdata <= {3'b0, c.node_count};
        CFG_START_AS_LEADER:  cfg_wdata <= {7'b0, c.start_as_leader};
        CFG_HEARTBEAT_PERIOD: cfg_wdata <= c.heartbeat_period;
        CFG_LEADER_TIMEOUT:   cfg_wdata <= c.leader_timeout;
        CFG_ELECTION_WAIT:    cfg_wdata <= c.election_wait;
        CFG_CHECK_PERIOD:     cfg_wdata <= c.check_period;
        default:              cfg_wdata <= '0;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs = c;
    settings_loaded++;
  endtask

  function automatic plan_row_t ev(input logic [2:0] m, input logic [1:0] t,
                                   input logic [3:0] s, input logic [3:0] a,
                                   input bit typed = 1'b0, input logic [3:0] ld = '0,
                                   input bit il = 1'b0);
    plan_row_t r;
    r.kind          = ROW_ITEM;
    r.regs          = '0;
    r.mode          = m;
    r.msg           = t;
    r.sender        = s;
    r.src           = a;
    r.typed         = typed;
    r.exp_leader    = ld;
    r.exp_is_leader = il;
    return r;
  endfunction

  function automatic plan_row_t setting(input cfg_t c);
    plan_row_t r;
    r = ev(MODE_TICK, MSG_HEARTBEAT, 4'd0, 4'd0);
    r.kind = ROW_CFG;
    r.regs = c;
    return r;
  endfunction

  function automatic void match(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch_results
    node_out_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_out.size() == 0) begin
        $error("result arrived with nothing expected");
        mismatches++;
      end else begin
        want = pending_out.pop_front();
        match("send_valid", want.send_valid, out_ch.send_valid);
        match("send_type", int'(want.send_type), int'(out_ch.send_type));
        match("broadcast", want.broadcast, out_ch.broadcast);
        match("dest_id", want.dest_id, out_ch.dest_id);
        match("leader_id", want.leader_id, out_ch.leader_id);
        match("is_leader", want.is_leader, out_ch.is_leader);
        match("last", want.last, out_ch.last);
        results_seen++;
      end
    end
  end

  initial begin : result_sink
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(4_000_000);
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : stimulus
    plan_row_t  plan[$];
    cfg_t       c;
    int         pick;
    int         quota;
    logic [3:0] who;
    logic [3:0] addr;
    bit         pressure_done;

    pressure_done     = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = '0;
    in_ch.msg_type    = '0;
    in_ch.sender_id   = '0;
    in_ch.source_addr = '0;

    regs        = cfg_t'{4'd0, 5'd16, 1'b0, 8'd5, 8'd10, 8'd10, 8'd5};
    lead_flag   = 1'b0;
    cur_leader  = '0;
    campaigning = 1'b0;
    okays       = '0;
    alive       = 1'b1;
    since_hb    = '0;
    hb_left     = '0;
    check_left  = '0;
    elect_left  = '0;

    // reset defaults, unused modes, failed-node handling
    plan.push_back(ev(MODE_TICK, MSG_HEARTBEAT, 4'd0, 4'd0, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_SPARE_LO, MSG_OKAY, 4'd15, 4'd15, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_SPARE_HI, MSG_LEADER, 4'd9, 4'd6, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_MSG, MSG_HEARTBEAT, 4'd0, 4'd0, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_FAIL, MSG_HEARTBEAT, 4'd0, 4'd0, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_MSG, MSG_ELECTION, 4'd15, 4'd15, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_START, MSG_HEARTBEAT, 4'd0, 4'd0, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_FAIL, MSG_HEARTBEAT, 4'd0, 4'd0, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_RECOVER, MSG_HEARTBEAT, 4'd0, 4'd0, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_RECOVER, MSG_HEARTBEAT, 4'd0, 4'd0, 1'b1, 4'd0, 1'b0));
    plan.push_back(ev(MODE_TICK, MSG_HEARTBEAT, 4'd0, 4'd0));
    // lowest id wins an election with every higher node targeted
    plan.push_back(setting(cfg_t'{4'd0, 5'd16, 1'b0, 8'd5, 8'd10, 8'd1, 8'd5}));
    plan.push_back(ev(MODE_MSG, MSG_ELECTION, 4'd15, 4'd15));
    plan.push_back(ev(MODE_TICK, MSG_HEARTBEAT, 4'd0, 4'd0));
    plan.push_back(ev(MODE_TICK, MSG_HEARTBEAT, 4'd0, 4'd0));
    plan.push_back(ev(MODE_MSG, MSG_OKAY, 4'd7, 4'd7, 1'b1, 4'd0, 1'b1));
    plan.push_back(ev(MODE_MSG, MSG_LEADER, 4'd15, 4'd15, 1'b1, 4'd15, 1'b0));
    // top id starts as leader, zero periods, no election targets
    plan.push_back(setting(cfg_t'{4'd15, 5'd1, 1'b1, 8'd0, 8'd255, 8'd1, 8'd0}));
    plan.push_back(ev(MODE_START, MSG_HEARTBEAT, 4'd0, 4'd0));
    plan.push_back(ev(MODE_TICK, MSG_HEARTBEAT, 4'd0, 4'd0));
    plan.push_back(ev(MODE_MSG, MSG_ELECTION, 4'd3, 4'd3));
    plan.push_back(ev(MODE_FAIL, MSG_HEARTBEAT, 4'd0, 4'd0, 1'b1, 4'd15, 1'b1));
    plan.push_back(ev(MODE_RECOVER, MSG_HEARTBEAT, 4'd0, 4'd0, 1'b1, 4'd15, 1'b1));
    plan.push_back(ev(MODE_TICK, MSG_HEARTBEAT, 4'd0, 4'd0));
    // node count above sixteen, zero timeout forces an election at the first check
    plan.push_back(setting(cfg_t'{4'd3, 5'd31, 1'b0, 8'd255, 8'd0, 8'd255, 8'd0}));
    plan.push_back(ev(MODE_MSG, MSG_LEADER, 4'd9, 4'd9, 1'b1, 4'd9, 1'b0));
    plan.push_back(ev(MODE_TICK, MSG_HEARTBEAT, 4'd0, 4'd0));
    plan.push_back(ev(MODE_MSG, MSG_OKAY, 4'd12, 4'd12, 1'b1, 4'd9, 1'b0));
    plan.push_back(ev(MODE_MSG, MSG_HEARTBEAT, 4'd9, 4'd9, 1'b1, 4'd9, 1'b0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) load_regs(plan[k].regs);
      else offer(plan[k].mode, plan[k].msg, plan[k].sender, plan[k].src, plan[k].typed,
                 plan[k].exp_leader, plan[k].exp_is_leader);
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: c = cfg_t'{4'd0, 5'd16, 1'b1, 8'd1, 8'd1, 8'd255, 8'd1};
        3: c = cfg_t'{4'd15, 5'd31, 1'b1, 8'd255, 8'd255, 8'd1, 8'd255};
        4: c = cfg_t'{4'($urandom), 5'd0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0};
        default: begin
          c.self_id          = 4'($urandom);
          c.node_count       = 5'($urandom);
          c.start_as_leader  = 1'($urandom);
          c.heartbeat_period = 8'($urandom_range(1, 6));
          c.leader_timeout   = 8'($urandom_range(0, 8));
          c.election_wait    = 8'($urandom_range(0, 8));
          c.check_period     = 8'($urandom_range(0, 4));
        end
      endcase
      load_regs(c);
      if (p == 5) idle_on = 1'b0;
      quota = requests_sent + 12;
      while (requests_sent < quota) begin
        if (p == 2 && !pressure_done) begin
          hold_req      = 1'b1;
          pressure_done = 1'b1;
        end
        pick = $urandom_range(0, 99);
        who  = 4'($urandom);
        addr = 4'($urandom);
        if (pick < 40) begin
          repeat ($urandom_range(1, 6))
            offer(MODE_TICK, 2'($urandom), 4'($urandom), 4'($urandom));
        end else if (pick < 52) begin
          offer(MODE_MSG, MSG_ELECTION, who, addr);
          repeat ($urandom_range(0, 3))
            offer(MODE_MSG, MSG_OKAY, 4'($urandom), 4'($urandom));
        end else if (pick < 62) begin
          offer(MODE_MSG, MSG_LEADER, who, addr);
          repeat ($urandom_range(1, 4)) begin
            offer(MODE_TICK, 2'($urandom), 4'($urandom), 4'($urandom));
            offer(MODE_MSG, MSG_HEARTBEAT, who, 4'($urandom));
          end
        end else if (pick < 70) begin
          offer(MODE_MSG, MSG_HEARTBEAT, who, addr);
        end else if (pick < 75) begin
          offer(MODE_START, 2'($urandom), who, addr);
        end else if (pick < 80) begin
          offer(MODE_FAIL, 2'($urandom), who, addr);
          repeat ($urandom_range(0, 3))
            offer(MODE_MSG, 2'($urandom), 4'($urandom), 4'($urandom));
          offer(MODE_RECOVER, 2'($urandom), 4'($urandom), 4'($urandom));
        end else if (pick < 83) begin
          // drive the okay count into saturation
          offer(MODE_MSG, MSG_ELECTION, who, addr);
          repeat (33) offer(MODE_MSG, MSG_OKAY, 4'($urandom), 4'($urandom));
          offer(MODE_TICK, 2'($urandom), 4'($urandom), 4'($urandom));
        end else if (pick < 88) begin
          offer(3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), 2'($urandom), who, addr);
        end else begin
          offer(3'($urandom), 2'($urandom), who, addr);
        end
      end
      if (p == 4) begin
        // largest timeout with a check every tick: silence alone starts no election
        load_regs(cfg_t'{4'($urandom), 5'($urandom), 1'b0, 8'd1, 8'd255, 8'd1, 8'd1});
        offer(MODE_RECOVER, MSG_HEARTBEAT, 4'd0, 4'd0);
        offer(MODE_MSG, MSG_LEADER, 4'($urandom), 4'($urandom));
        offer(MODE_MSG, MSG_OKAY, 4'($urandom), 4'($urandom));
        repeat (10) offer(MODE_TICK, 2'($urandom), 4'($urandom), 4'($urandom));
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("testbench: %0d requests, %0d results checked over %0d register settings",
             requests_sent, results_seen, settings_loaded);
    $display("testbench: ticks, messages, start, fail/recover, spare modes, long output stall");
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
